[rtl/uf2vd_pkg.sv]
// Shared types, codes and constants of the UF2 virtual disk sector handler.
package uf2vd_pkg;

   // Flash page geometry.
   localparam int unsigned PAGE_BYTES = 4096;
   localparam logic [31:0] PAGE_MASK  = 32'(PAGE_BYTES - 1);

   // UF2 block magic words.
   localparam logic [31:0] MAGIC_FIRST = 32'h0A32_4655;
   localparam logic [31:0] MAGIC_SECOND = 32'h9E5D_5157;
   localparam logic [31:0] MAGIC_FINAL = 32'h0AB1_6F30;

   // Register reset values.
   localparam logic [31:0] FAMILY_RESET = 32'h0000_0000;
   localparam logic [31:0] REGION_LOW_RESET = 32'h1D01_0000;
   localparam logic [31:0] REGION_HIGH_RESET = 32'h1D08_0000;
   localparam logic [31:0] WINDOW_BASE_RESET = 32'h9D01_0000;

   // Sector numbers of the virtual FAT32 volume.
   localparam logic [21:0] SECT_MBR = 22'd0;
   localparam logic [21:0] SECT_VBR = 22'd1;
   localparam logic [21:0] SECT_FSINFO = 22'd2;
   localparam logic [21:0] SECT_VBR_BACKUP = 22'd7;
   localparam logic [21:0] SECT_FSINFO_BACKUP = 22'd8;
   localparam logic [21:0] SECT_FAT_WRITE0 = 22'd9;
   localparam logic [21:0] SECT_FAT_WRITE1 = 22'd73;
   localparam logic [21:0] SECT_FAT0 = 22'(9 + 24);
   localparam logic [21:0] SECT_FAT1 = 22'(2057 + 24);
   localparam logic [21:0] SECT_ROOT = 22'(4105 + 24);

   // Register map, indexed by word address.
   localparam int unsigned CSR_ADDR_BITS = 4;
   typedef enum logic [1:0] {
      CSR_FAMILY      = 2'd0,
      CSR_REGION_LOW  = 2'd1,
      CSR_REGION_HIGH = 2'd2,
      CSR_WINDOW_BASE = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_ZERO   = 3'd0,
      KIND_MBR    = 3'd1,
      KIND_VBR    = 3'd2,
      KIND_FSINFO = 3'd3,
      KIND_FAT    = 3'd4,
      KIND_ROOT   = 3'd5,
      KIND_NONE   = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      OUTCOME_NONE     = 3'd0,
      OUTCOME_FAT      = 3'd1,
      OUTCOME_PROGRAM  = 3'd2,
      OUTCOME_RANGE    = 3'd3,
      OUTCOME_IGNORED  = 3'd4
   } outcome_type;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      logic [31:0] family_code;
      logic [31:0] app_region_low;
      logic [31:0] app_region_high;
      logic [31:0] flash_window_base;
   } cfg_type;

   // Classified beat handed from the decode stage to the tracking stage.
   typedef struct packed {
      kind_type    kind;
      logic        is_write;
      logic        fat_capture;
      logic        uf2_ok;
      logic        in_range;
      logic [31:0] rel;
      logic [31:0] total;
   } dec_type;

endpackage

[rtl/uf2_virtual_disk_sector_handler.sv]
// Top level of the UF2 virtual disk sector handler.
//
//   Channel   Direction   Handshake                     Beat content
//   req_      in          req_valid / req_ready         one host sector access
//   rsp_      out         rsp_valid / rsp_ready         classification and outcome
//   csr_      in/out      psel, penable, pwrite, pready four 32-bit registers
//
// A beat taken is decoded into the first stage register and then moves on into the result
// register; a beat can be taken every cycle while the result side is not stalled.
// Synchronous active-high reset empties both stages, clears the upload counters and
// loads the default register values.
// A stalled result holds its stage; the first stage keeps taking beats until it is
// also full, and then req_ready drops.
module uf2_virtual_disk_sector_handler import uf2vd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_action,
   input  logic [21:0]              req_sector_number,
   input  logic [31:0]              req_magic_first,
   input  logic [31:0]              req_magic_second,
   input  logic [31:0]              req_magic_final,
   input  logic [31:0]              req_block_family,
   input  logic [31:0]              req_target_address,
   input  logic [31:0]              req_total_blocks,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_sector_kind,
   output logic [2:0]               rsp_write_outcome,
   output logic [31:0]              rsp_page_address,
   output logic [11:0]              rsp_page_offset,
   output logic                     rsp_upload_active,
   output logic                     rsp_upload_done,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   cfg_type cfg;
   dec_type dec;
   logic    dec_valid;
   logic    dec_ready;

   // Register file; the datapath sees the registers directly.
   uf2vd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Decode stage: sector classification, header check and region compare.
   uf2vd_decode u_decode (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_sector_number  (req_sector_number),
      .req_magic_first    (req_magic_first),
      .req_magic_second   (req_magic_second),
      .req_magic_final    (req_magic_final),
      .req_block_family   (req_block_family),
      .req_target_address (req_target_address),
      .req_total_blocks   (req_total_blocks),
      .dec_valid          (dec_valid),
      .dec_ready          (dec_ready),
      .dec                (dec)
   );

   // Tracking stage: the block counters live here, so consecutive beats see
   // each other's updates without a gap.
   uf2vd_track u_track (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .dec_valid         (dec_valid),
      .dec_ready         (dec_ready),
      .dec               (dec),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sector_kind   (rsp_sector_kind),
      .rsp_write_outcome (rsp_write_outcome),
      .rsp_page_address  (rsp_page_address),
      .rsp_page_offset   (rsp_page_offset),
      .rsp_upload_active (rsp_upload_active),
      .rsp_upload_done   (rsp_upload_done)
   );

endmodule

[rtl/uf2vd_csr.sv]
// Configuration register file with an APB-style access port.
module uf2vd_csr import uf2vd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign index = csr_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign write_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            CSR_FAMILY:      cfg_in.family_code = csr_pwdata;
            CSR_REGION_LOW:  cfg_in.app_region_low = csr_pwdata;
            CSR_REGION_HIGH: cfg_in.app_region_high = csr_pwdata;
            CSR_WINDOW_BASE: cfg_in.flash_window_base = csr_pwdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_FAMILY:      csr_prdata = cfg_ff.family_code;
         CSR_REGION_LOW:  csr_prdata = cfg_ff.app_region_low;
         CSR_REGION_HIGH: csr_prdata = cfg_ff.app_region_high;
         CSR_WINDOW_BASE: csr_prdata = cfg_ff.flash_window_base;
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.family_code <= FAMILY_RESET;
         cfg_ff.app_region_low <= REGION_LOW_RESET;
         cfg_ff.app_region_high <= REGION_HIGH_RESET;
         cfg_ff.flash_window_base <= WINDOW_BASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/uf2vd_decode.sv]
// Input stage: classifies a request beat and checks the UF2 header.
module uf2vd_decode import uf2vd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [21:0] req_sector_number,
   input  logic [31:0] req_magic_first,
   input  logic [31:0] req_magic_second,
   input  logic [31:0] req_magic_final,
   input  logic [31:0] req_block_family,
   input  logic [31:0] req_target_address,
   input  logic [31:0] req_total_blocks,
   output logic        dec_valid,
   input  logic        dec_ready,
   output dec_type     dec
);

   logic    valid_ff;
   logic    valid_in;
   dec_type dec_ff;
   dec_type dec_in;
   logic    take;

   assign req_ready = !valid_ff || dec_ready;
   assign take = req_valid && req_ready;
   assign dec_valid = valid_ff;
   assign dec = dec_ff;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (dec_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_comb begin
      dec_in.is_write = req_action;
      dec_in.kind = KIND_NONE;
      if (!req_action) begin
         unique case (req_sector_number)
            SECT_MBR:                       dec_in.kind = KIND_MBR;
            SECT_VBR, SECT_VBR_BACKUP:       dec_in.kind = KIND_VBR;
            SECT_FSINFO, SECT_FSINFO_BACKUP: dec_in.kind = KIND_FSINFO;
            SECT_FAT0, SECT_FAT1:           dec_in.kind = KIND_FAT;
            SECT_ROOT:                      dec_in.kind = KIND_ROOT;
            default:                        dec_in.kind = KIND_ZERO;
         endcase
      end
      dec_in.fat_capture = (req_sector_number == SECT_FAT_WRITE0) ||
                           (req_sector_number == SECT_FAT_WRITE1);
      dec_in.uf2_ok = (req_magic_first == MAGIC_FIRST) &&
                      (req_magic_second == MAGIC_SECOND) &&
                      (req_magic_final == MAGIC_FINAL) &&
                      (req_block_family == cfg.family_code);
      // An empty region fails at least one of the compares by construction.
      dec_in.in_range = (req_target_address >= cfg.app_region_low) &&
                        (req_target_address < cfg.app_region_high);
      dec_in.rel = req_target_address - cfg.app_region_low;
      dec_in.total = req_total_blocks;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         dec_ff <= dec_in;
      end
   end

endmodule

[rtl/uf2vd_track.sv]
// Result stage: upload block counting, page address and the result register.
module uf2vd_track import uf2vd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        dec_valid,
   output logic        dec_ready,
   input  dec_type     dec,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_sector_kind,
   output logic [2:0]  rsp_write_outcome,
   output logic [31:0] rsp_page_address,
   output logic [11:0] rsp_page_offset,
   output logic        rsp_upload_active,
   output logic        rsp_upload_done
);

   logic        valid_ff;
   logic        valid_in;
   logic [31:0] expected_count_ff;
   logic [31:0] expected_count_in;
   logic [31:0] written_count_ff;
   logic [31:0] written_count_in;
   kind_type    kind_ff;
   outcome_type outcome_ff;
   outcome_type outcome_in;
   logic [31:0] page_address_ff;
   logic [31:0] page_address_in;
   logic [11:0] page_offset_ff;
   logic [11:0] page_offset_in;
   logic        active_ff;
   logic        active_in;
   logic        done_ff;
   logic        done_in;

   logic        move;
   logic        accepted;
   logic        latch;
   logic [31:0] expected_eff;
   logic [31:0] written_inc;
   logic [31:0] in_page;

   assign dec_ready = !valid_ff || rsp_ready;
   assign move = dec_valid && dec_ready;

   always_comb begin
      if (move) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_comb begin
      accepted = dec.is_write && !dec.fat_capture && dec.uf2_ok;
      // The first accepted block of an upload latches the expected count.
      latch = (expected_count_ff == '0);
      expected_eff = latch ? dec.total : expected_count_ff;
      written_inc = (latch ? 32'd0 : written_count_ff) + 32'd1;
      in_page = dec.rel & PAGE_MASK;

      outcome_in = OUTCOME_NONE;
      page_address_in = '0;
      page_offset_in = '0;
      if (dec.is_write) begin
         if (dec.fat_capture) begin
            outcome_in = OUTCOME_FAT;
         end else if (!dec.uf2_ok) begin
            outcome_in = OUTCOME_IGNORED;
         end else if (dec.in_range) begin
            outcome_in = OUTCOME_PROGRAM;
            page_address_in = cfg.flash_window_base + (dec.rel & ~PAGE_MASK);
            page_offset_in = in_page[11:0];
         end else begin
            outcome_in = OUTCOME_RANGE;
         end
      end

      expected_count_in = expected_count_ff;
      written_count_in = written_count_ff;
      if (accepted) begin
         active_in = (expected_eff != '0);
         done_in = (written_inc >= expected_eff);
         if (done_in) begin
            // A finished upload restarts the tracking.
            expected_count_in = '0;
            written_count_in = '0;
         end else begin
            expected_count_in = expected_eff;
            written_count_in = written_inc;
         end
      end else begin
         active_in = (expected_count_ff != '0);
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         expected_count_ff <= '0;
         written_count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (move) begin
            expected_count_ff <= expected_count_in;
            written_count_ff <= written_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         kind_ff <= dec.kind;
         outcome_ff <= outcome_in;
         page_address_ff <= page_address_in;
         page_offset_ff <= page_offset_in;
         active_ff <= active_in;
         done_ff <= done_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_sector_kind = kind_ff;
   assign rsp_write_outcome = outcome_ff;
   assign rsp_page_address = page_address_ff;
   assign rsp_page_offset = page_offset_ff;
   assign rsp_upload_active = active_ff;
   assign rsp_upload_done = done_ff;

endmodule

[sim/uf2_virtual_disk_sector_handler_tb.sv]
// Self-checking testbench for the UF2 virtual disk sector handler.
module uf2_virtual_disk_sector_handler_tb;
   import uf2vd_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   // Two register stages inside the block, plus a little margin.
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD_CYCLES = 60;

   // Direction of a host sector access.
   localparam logic ACTION_READ = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   // One host sector access as it travels on the request channel.
   typedef struct packed {
      logic        action;
      logic [21:0] sector;
      logic [31:0] magic_first;
      logic [31:0] magic_second;
      logic [31:0] magic_final;
      logic [31:0] family;
      logic [31:0] target;
      logic [31:0] total;
   } sector_access_type;

   // Classification and upload outcome of one access.
   typedef struct packed {
      kind_type    kind;
      outcome_type outcome;
      logic [31:0] page_address;
      logic [11:0] page_offset;
      logic        active;
      logic        done;
   } sector_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = ACTION_READ;
   logic [21:0] req_sector_number = '0;
   logic [31:0] req_magic_first = '0;
   logic [31:0] req_magic_second = '0;
   logic [31:0] req_magic_final = '0;
   logic [31:0] req_block_family = '0;
   logic [31:0] req_target_address = '0;
   logic [31:0] req_total_blocks = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_sector_kind;
   logic [2:0]  rsp_write_outcome;
   logic [31:0] rsp_page_address;
   logic [11:0] rsp_page_offset;
   logic        rsp_upload_active;
   logic        rsp_upload_done;

   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0]              csr_pwdata = '0;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   uf2_virtual_disk_sector_handler dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_sector_number  (req_sector_number),
      .req_magic_first    (req_magic_first),
      .req_magic_second   (req_magic_second),
      .req_magic_final    (req_magic_final),
      .req_block_family   (req_block_family),
      .req_target_address (req_target_address),
      .req_total_blocks   (req_total_blocks),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sector_kind    (rsp_sector_kind),
      .rsp_write_outcome  (rsp_write_outcome),
      .rsp_page_address   (rsp_page_address),
      .rsp_page_offset    (rsp_page_offset),
      .rsp_upload_active  (rsp_upload_active),
      .rsp_upload_done    (rsp_upload_done),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // Our own copy of the register file and of the upload block counters.
   // The registers only change while the block is idle, so the copy is
   // updated at the edge where the register write lands.
   cfg_type csr_shadow = '{
      family_code:       FAMILY_RESET,
      app_region_low:    REGION_LOW_RESET,
      app_region_high:   REGION_HIGH_RESET,
      flash_window_base: WINDOW_BASE_RESET
   };
   logic [31:0] blocks_expected = '0;
   logic [31:0] blocks_written = '0;

   // Accesses waiting to be offered, and results predicted for accepted beats.
   sector_access_type pending_accesses[$];
   sector_result_type predicted_results[$];

   int unsigned mismatch_count = 0;
   // Random idling on both channels is switched off for the closing stretch.
   bit          idle_enabled = 1'b1;
   // The stimulus process bumps this to ask the result side for a long hold.
   int unsigned hold_requests = 0;

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Works out the result of one accepted access and advances the upload
   // counters exactly as the block should.
   function automatic sector_result_type predict_sector_result(sector_access_type a);
      sector_result_type r;
      logic [31:0]       rel;
      logic [31:0]       in_page;
      r.kind = KIND_NONE;
      r.outcome = OUTCOME_NONE;
      r.page_address = '0;
      r.page_offset = '0;
      r.done = 1'b0;
      if (a.action == ACTION_READ) begin
         case (a.sector)
            SECT_MBR:                        r.kind = KIND_MBR;
            SECT_VBR, SECT_VBR_BACKUP:       r.kind = KIND_VBR;
            SECT_FSINFO, SECT_FSINFO_BACKUP: r.kind = KIND_FSINFO;
            SECT_FAT0, SECT_FAT1:            r.kind = KIND_FAT;
            SECT_ROOT:                       r.kind = KIND_ROOT;
            default:                         r.kind = KIND_ZERO;
         endcase
      end else if (a.sector == SECT_FAT_WRITE0 || a.sector == SECT_FAT_WRITE1) begin
         // The host rewriting the FAT is captured without any UF2 check.
         r.outcome = OUTCOME_FAT;
      end else if (a.magic_first == MAGIC_FIRST && a.magic_second == MAGIC_SECOND &&
                   a.magic_final == MAGIC_FINAL && a.family == csr_shadow.family_code) begin
         // The first accepted block of an upload latches the block count.
         if (blocks_expected == 32'd0) begin
            blocks_expected = a.total;
            blocks_written = '0;
         end
         if (a.target >= csr_shadow.app_region_low && a.target < csr_shadow.app_region_high) begin
            rel = a.target - csr_shadow.app_region_low;
            in_page = rel & PAGE_MASK;
            r.outcome = OUTCOME_PROGRAM;
            r.page_address = csr_shadow.flash_window_base + (rel - in_page);
            r.page_offset = in_page[11:0];
         end else begin
            r.outcome = OUTCOME_RANGE;
         end
         blocks_written = blocks_written + 32'd1;
         if (blocks_written >= blocks_expected) r.done = 1'b1;
      end else begin
         r.outcome = OUTCOME_IGNORED;
      end
      // Active reflects the count after the latch, even on the closing block.
      r.active = (blocks_expected != 32'd0);
      if (r.done) begin
         blocks_expected = '0;
         blocks_written = '0;
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch on %s at %0t: expected 0x%08h, got 0x%08h", field, $realtime,
                  want, got);
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus builders.
   // ------------------------------------------------------------------

   // Pure noise: every field random, so writes almost never carry the magics.
   function automatic sector_access_type random_access();
      sector_access_type a;
      a.action = 1'($urandom_range(0, 1));
      a.sector = 22'($urandom);
      a.magic_first = $urandom;
      a.magic_second = $urandom;
      a.magic_final = $urandom;
      a.family = $urandom;
      a.target = $urandom;
      a.total = $urandom;
      return a;
   endfunction

   // A read carries random header fields that the block must disregard.
   function automatic sector_access_type read_access(logic [21:0] sector);
      sector_access_type a;
      a = random_access();
      a.action = ACTION_READ;
      a.sector = sector;
      return a;
   endfunction

   // A well-formed UF2 block for the current family, on a data sector.
   function automatic sector_access_type good_block(logic [31:0] target, logic [31:0] total);
      sector_access_type a;
      a.action = ACTION_WRITE;
      a.sector = 22'($urandom_range(int'(SECT_ROOT) + 1, 22'h3F_FFFF));
      a.magic_first = MAGIC_FIRST;
      a.magic_second = MAGIC_SECOND;
      a.magic_final = MAGIC_FINAL;
      a.family = csr_shadow.family_code;
      a.target = target;
      a.total = total;
      return a;
   endfunction

   // Spoils one bit of one header word, so the block must be ignored.
   function automatic sector_access_type break_header(sector_access_type a);
      logic [31:0] flip;
      flip = 32'd1 << $urandom_range(0, 31);
      case ($urandom_range(0, 3))
         0:       a.magic_first ^= flip;
         1:       a.magic_second ^= flip;
         2:       a.magic_final ^= flip;
         default: a.family ^= flip;
      endcase
      return a;
   endfunction

   // Mostly the special volume sectors and their neighbors, sometimes anywhere.
   function automatic logic [21:0] pick_sector();
      logic [21:0] named[10];
      named = '{SECT_MBR, SECT_VBR, SECT_FSINFO, SECT_VBR_BACKUP, SECT_FSINFO_BACKUP,
                SECT_FAT_WRITE0, SECT_FAT_WRITE1, SECT_FAT0, SECT_FAT1, SECT_ROOT};
      case ($urandom_range(0, 3))
         0, 1:    return named[$urandom_range(0, 9)];
         2:       return named[$urandom_range(0, 9)] + 22'($urandom_range(0, 2)) - 22'd1;
         default: return 22'($urandom);
      endcase
   endfunction

   // Targets cluster inside the application region, with its borders and
   // the addresses just outside them hit often.
   function automatic logic [31:0] pick_target();
      logic [31:0] span;
      span = csr_shadow.app_region_high - csr_shadow.app_region_low;
      case ($urandom_range(0, 9))
         0: return csr_shadow.app_region_low;
         1: return csr_shadow.app_region_high - 32'd1;
         2: return csr_shadow.app_region_high;
         3: return csr_shadow.app_region_low - 32'd1;
         4: return $urandom;
         default: begin
            if (csr_shadow.app_region_high > csr_shadow.app_region_low)
               return csr_shadow.app_region_low + ($urandom % span);
            return $urandom;
         end
      endcase
   endfunction

   // Queues about budget accesses. Most of them form uploads: a run of valid
   // blocks whose first beat gives the count, interleaved with reads, FAT
   // writes, spoiled headers and now and then an upload cut short.
   task automatic fill_random(int unsigned budget);
      int unsigned       made;
      int unsigned       blocks;
      int unsigned       k;
      bit                cut;
      sector_access_type a;
      made = 0;
      while (made < budget) begin
         case ($urandom_range(0, 9))
            0: begin
               pending_accesses.push_back(random_access());
               made++;
            end
            1, 2: begin
               pending_accesses.push_back(read_access(pick_sector()));
               made++;
            end
            default: begin
               blocks = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                    : $urandom_range(0, 5);
               cut = 1'b0;
               for (k = 0; k < ((blocks == 0) ? 1 : blocks) && !cut; k++) begin
                  // Later blocks carry arbitrary counts, which only the first one latches.
                  a = good_block(pick_target(), (k == 0) ? blocks : $urandom);
                  case ($urandom_range(0, 15))
                     0: a.sector = $urandom_range(0, 1) ? SECT_FAT_WRITE0 : SECT_FAT_WRITE1;
                     1: begin
                        pending_accesses.push_back(break_header(a));
                        made++;
                     end
                     2: begin
                        pending_accesses.push_back(read_access(pick_sector()));
                        made++;
                     end
                     3: a = break_header(a);
                     4: cut = (k > 0);
                     default: ;
                  endcase
                  if (!cut) begin
                     pending_accesses.push_back(a);
                     made++;
                  end
               end
            end
         endcase
      end
   endtask

   // One APB write followed by a read back of the same register.
   task automatic write_register(csr_index_type index, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'(4 * int'(index));
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // The register takes the value at this edge.
      case (index)
         CSR_FAMILY:      csr_shadow.family_code = value;
         CSR_REGION_LOW:  csr_shadow.app_region_low = value;
         CSR_REGION_HIGH: csr_shadow.app_region_high = value;
         CSR_WINDOW_BASE: csr_shadow.flash_window_base = value;
         default: ;
      endcase
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== value) report_mismatch("register read back", value, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_registers(logic [31:0] family, logic [31:0] low, logic [31:0] high,
                                logic [31:0] base);
      write_register(CSR_FAMILY, family);
      write_register(CSR_REGION_LOW, low);
      write_register(CSR_REGION_HIGH, high);
      write_register(CSR_WINDOW_BASE, base);
      @(negedge clock);
   endtask

   // Lets the sender run dry and every predicted result arrive, then lets the
   // pipeline settle for SETTLE_CYCLES before anything else happens.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_accesses.size() != 0 || req_valid || predicted_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Driver: offers queued accesses on the request channel. The result of a
   // beat is predicted at the edge where it is accepted, so the prediction
   // order matches the order in which the block sees the beats.
   // ------------------------------------------------------------------
   sector_access_type offered_access;
   logic              offer_next;
   int unsigned       send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         offer_next = req_valid;
         if (req_valid && req_ready) begin
            predicted_results.push_back(predict_sector_result(offered_access));
            offer_next = 1'b0;
         end
         // A beat still waiting keeps valid and payload untouched.
         if (!offer_next) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
               // This cycle starts a random gap in the offers.
               send_gap = $urandom_range(0, 7);
            end else if (pending_accesses.size() != 0) begin
               offered_access = pending_accesses.pop_front();
               req_action <= offered_access.action;
               req_sector_number <= offered_access.sector;
               req_magic_first <= offered_access.magic_first;
               req_magic_second <= offered_access.magic_second;
               req_magic_final <= offered_access.magic_final;
               req_block_family <= offered_access.family;
               req_target_address <= offered_access.target;
               req_total_blocks <= offered_access.total;
               offer_next = 1'b1;
            end
         end
         req_valid <= offer_next;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks every accepted result beat against the oldest prediction
   // and drives rsp_ready, with short random stalls and, on request, one long
   // hold that backs the block up until it refuses new requests.
   // ------------------------------------------------------------------
   sector_result_type oldest_result;
   logic              ready_next;
   int unsigned       stall_left = 0;
   int unsigned       hold_left = 0;
   int unsigned       holds_served = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result beat at %0t with nothing predicted: kind %0d outcome %0d",
                           $realtime, rsp_sector_kind, rsp_write_outcome);
               end
            end else begin
               oldest_result = predicted_results.pop_front();
               if (rsp_sector_kind !== oldest_result.kind)
                  report_mismatch("sector_kind", 32'(oldest_result.kind), 32'(rsp_sector_kind));
               if (rsp_write_outcome !== oldest_result.outcome)
                  report_mismatch("write_outcome", 32'(oldest_result.outcome),
                                  32'(rsp_write_outcome));
               if (rsp_page_address !== oldest_result.page_address)
                  report_mismatch("page_address", oldest_result.page_address, rsp_page_address);
               if (rsp_page_offset !== oldest_result.page_offset)
                  report_mismatch("page_offset", 32'(oldest_result.page_offset),
                                  32'(rsp_page_offset));
               if (rsp_upload_active !== oldest_result.active)
                  report_mismatch("upload_active", 32'(oldest_result.active),
                                  32'(rsp_upload_active));
               if (rsp_upload_done !== oldest_result.done)
                  report_mismatch("upload_done", 32'(oldest_result.done), 32'(rsp_upload_done));
            end
         end
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence. All queue and flag updates happen on the falling edge,
   // away from the edge where the driver and the monitor act.
   // ------------------------------------------------------------------
   initial begin
      sector_access_type fat_write;
      logic [31:0]       region_start;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed beats with the registers at their reset values: every read
      // class, both FAT capture sectors, spoiled headers, an upload with a
      // zero count that completes at once, a three-block upload at the upper
      // region border and a one-block upload aimed just below the region.
      pending_accesses.push_back(read_access(SECT_MBR));
      pending_accesses.push_back(read_access(SECT_VBR));
      pending_accesses.push_back(read_access(SECT_FSINFO));
      pending_accesses.push_back(read_access(SECT_VBR_BACKUP));
      pending_accesses.push_back(read_access(SECT_FSINFO_BACKUP));
      pending_accesses.push_back(read_access(SECT_FAT0));
      pending_accesses.push_back(read_access(SECT_FAT1));
      pending_accesses.push_back(read_access(SECT_ROOT));
      pending_accesses.push_back(read_access(22'd3));
      pending_accesses.push_back(read_access(22'h3F_FFFF));
      fat_write = good_block(csr_shadow.app_region_low, 32'd1);
      fat_write.sector = SECT_FAT_WRITE0;
      pending_accesses.push_back(fat_write);
      pending_accesses.push_back('{ACTION_WRITE, SECT_FAT_WRITE1, '1, '1, '1, '1, '1, '1});
      pending_accesses.push_back(break_header(good_block(csr_shadow.app_region_low, 32'd1)));
      pending_accesses.push_back(break_header(good_block(csr_shadow.app_region_low, 32'd1)));
      pending_accesses.push_back(good_block(csr_shadow.app_region_low, 32'd0));
      pending_accesses.push_back(good_block(csr_shadow.app_region_low + 32'h123, 32'd3));
      pending_accesses.push_back(good_block(csr_shadow.app_region_high - 32'd1, '1));
      pending_accesses.push_back(read_access(SECT_ROOT));
      pending_accesses.push_back(good_block(csr_shadow.app_region_high, 32'd0));
      pending_accesses.push_back(good_block(csr_shadow.app_region_low - 32'd1, 32'd1));
      pending_accesses.push_back(good_block(32'd0, 32'd2));
      pending_accesses.push_back(good_block('1, 32'd0));
      wait_drained();

      // A typical family and the default region; the result side holds off
      // for a long stretch while the sender keeps offering beats.
      set_registers(32'hE48B_FF56, REGION_LOW_RESET, REGION_HIGH_RESET, WINDOW_BASE_RESET);
      fill_random(150);
      hold_requests++;
      wait_drained();

      // All-ones family, the widest region and a window base that makes the
      // page address wrap. The sender pauses halfway until all results are in.
      set_registers('1, '0, '1, 32'hFFFF_F000);
      fill_random(60);
      wait_drained();
      fill_random(70);
      wait_drained();

      // Zero family and a region whose end lies below its start: nothing is
      // in range, so every accepted block lands out of range.
      set_registers('0, 32'hFFFF_F000, 32'h0000_1000, '0);
      fill_random(80);
      wait_drained();

      // Random registers; the last stretch runs with no idling on either side.
      region_start = $urandom;
      set_registers($urandom, region_start,
                    region_start + $urandom_range(32'h100, 32'h10_0000), $urandom);
      fill_random(100);
      wait_drained();
      idle_enabled = 1'b0;
      fill_random(50);
      wait_drained();

      if (mismatch_count == 0 && predicted_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #(CLOCK_PERIOD * 400000);
      $display("TEST FAILED");
      $finish;
   end

endmodule
